>>> hw/rtl/akc_pkg.sv
// ----------------------------------------------------------------------------
// akc_pkg
// Shared types and constants for the additive keystream byte cipher.
// ----------------------------------------------------------------------------
`default_nettype none

package akc_pkg;

    localparam int DATA_W = 8;
    localparam int RES_W  = 28;
    localparam int POOL_W = 27;
    localparam int BASE_W = 10;
    localparam int ADDR_W = 3;

    localparam logic [RES_W-1:0]  MODULUS_PRIME = 28'd224284387;
    localparam logic [RES_W-1:0]  SCALE_POWER   = 28'd100000000;
    localparam logic [BASE_W-1:0] DIGIT_BASE    = 10'd707;

    // The refill quotient from this reciprocal is low by at most one.
    localparam int                PRIME_SHIFT   = 28;
    localparam logic [POOL_W-1:0] PRIME_RECIP   = 27'd119685306;

    // This reciprocal gives the exact quotient by 707 for any 27-bit pool.
    localparam int                BASE_SHIFT    = 37;
    localparam logic [RES_W-1:0]  BASE_RECIP    = 28'd194397389;

    localparam logic [ADDR_W-3:0] REG_DIRECTION = 1'b0;

    typedef enum logic {
        MODE_ENCRYPT = 1'b0,
        MODE_DECRYPT = 1'b1
    } t_mode;

    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic              last;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_queue_out;

endpackage

`default_nettype wire

>>> hw/rtl/additive_keystream_byte_cipher.sv
// ----------------------------------------------------------------------------
// additive_keystream_byte_cipher
// Adds or subtracts a keystream digit to each data byte, modulo 256.
// ----------------------------------------------------------------------------
// Bytes enter on the s_ stream channel (tlast marks the end of a buffer) and
// leave on the m_ channel in the same order, one result per byte, with tlast
// copied. The APB register at address 0 selects encrypt (0) or decrypt (1);
// write it only while no item is in flight.
// Each item passes through the engine steps pop, pool check, reciprocal
// multiply for the divide by 707, digit and byte update, and the output load.
// When the digit pool runs low, a refill adds the steps multiply, remainder,
// one correction step and a new check; it happens about once every two
// bytes, and a new buffer starts with one.
// Until it is full, the input queue keeps accepting while the engine works
// or while a result waits on a stalled receiver; the engine holds its result
// until the output register is free. Reset empties the queue and the output
// register, clears the mode to encrypt and restarts the keystream.
// ----------------------------------------------------------------------------
`default_nettype none

module additive_keystream_byte_cipher
    import akc_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_s_tvalid,
    output logic                   o_s_tready,
    input  wire logic [DATA_W-1:0] i_s_tdata,   // [7:0] data_byte
    input  wire logic              i_s_tlast,
    output logic                   o_m_tvalid,
    input  wire logic              i_m_tready,
    output logic [DATA_W-1:0]      o_m_tdata,   // [7:0] out_byte
    output logic                   o_m_tlast,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    t_mode       r_mode;
    t_queue_out  w_q;
    logic        w_pop;
    logic        w_sel_dir;

    assign pready    = 1'b1;
    assign w_sel_dir = (paddr[ADDR_W-1:2] == REG_DIRECTION);
    assign prdata    = w_sel_dir ? {31'b0, r_mode} : 32'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_ENCRYPT;
        end else if (psel && penable && pwrite && pready && w_sel_dir) begin
            r_mode <= t_mode'(pwdata[0]);
        end
    end

    akc_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_q        (w_q),
        .i_pop      (w_pop)
    );

    akc_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_mode     (r_mode),
        .i_q        (w_q),
        .o_pop      (w_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

`default_nettype wire

>>> hw/rtl/akc_front.sv
// ----------------------------------------------------------------------------
// akc_front
// Input side: accepts stream items and holds them in a short queue.
// ----------------------------------------------------------------------------
`default_nettype none

module akc_front
    import akc_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_s_tvalid,
    output logic                   o_s_tready,
    input  wire logic [DATA_W-1:0] i_s_tdata,   // [7:0] data_byte
    input  wire logic              i_s_tlast,
    output t_queue_out             o_q,
    input  wire logic              i_pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W_Q = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0]   LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W_Q-1:0] FULL_CNT = CNT_W_Q'(DEPTH);

    t_item               r_mem [DEPTH];
    logic [PTR_W-1:0]    r_wptr;
    logic [PTR_W-1:0]    r_rptr;
    logic [CNT_W_Q-1:0]  r_count;
    logic                w_push;
    logic                w_pop;

    assign o_s_tready = (r_count != FULL_CNT);
    assign w_push     = i_s_tvalid && o_s_tready;
    assign w_pop      = i_pop && (r_count != '0);

    assign o_q.valid  = (r_count != '0);
    assign o_q.item   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= '{data: i_s_tdata, last: i_s_tlast};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wptr <= (r_wptr == LAST_PTR) ? '0 : r_wptr + 1'b1;
            end
            if (w_pop) begin
                r_rptr <= (r_rptr == LAST_PTR) ? '0 : r_rptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/akc_back.sv
// ----------------------------------------------------------------------------
// akc_back
// Keystream engine: refills the digit pool, extracts one digit per item with
// reciprocal multiplies and drives the registered output.
// ----------------------------------------------------------------------------
`default_nettype none

module akc_back
    import akc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_mode             i_mode,
    input  wire t_queue_out        i_q,
    output logic                   o_pop,
    output logic                   o_m_tvalid,
    input  wire logic              i_m_tready,
    output logic [DATA_W-1:0]      o_m_tdata,   // [7:0] out_byte
    output logic                   o_m_tlast
);

    localparam int MUL_W = RES_W + POOL_W;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_CHECK = 8'b0000_0010,
        ST_MUL   = 8'b0000_0100,
        ST_REM   = 8'b0000_1000,
        ST_FIX   = 8'b0001_0000,
        ST_DIV   = 8'b0010_0000,
        ST_KEY   = 8'b0100_0000,
        ST_EMIT  = 8'b1000_0000
    } t_state;

    t_state              r_state;
    logic [RES_W-1:0]    r_residue;
    logic [POOL_W-1:0]   r_pool;
    logic [POOL_W-1:0]   r_quot;
    logic [RES_W:0]      r_prod;
    logic [RES_W:0]      r_rem;
    t_item               r_item;
    logic                r_out_valid;
    t_item               r_out_item;

    logic [MUL_W-1:0]    w_mix_prod;
    logic [MUL_W-1:0]    w_pool_mul;
    logic [RES_W:0]      w_scaled;
    logic [RES_W:0]      w_quot_mul;
    logic                w_over;
    logic [RES_W-1:0]    w_fix;
    logic [DATA_W-1:0]   w_base_mul;
    logic [DATA_W-1:0]   w_key;
    logic [DATA_W-1:0]   w_result;
    logic                w_slot_free;

    assign w_mix_prod = MUL_W'(r_residue) * MUL_W'(PRIME_RECIP);
    assign w_scaled   = (RES_W+1)'(r_residue) * (RES_W+1)'(SCALE_POWER);
    assign w_quot_mul = (RES_W+1)'(r_quot) * (RES_W+1)'(MODULUS_PRIME);
    assign w_over     = (r_rem >= {1'b0, MODULUS_PRIME});
    assign w_fix      = r_rem[RES_W-1:0] - MODULUS_PRIME;

    assign w_pool_mul = MUL_W'(r_pool) * MUL_W'(BASE_RECIP);
    assign w_base_mul = DATA_W'(r_quot) * DATA_W'(DIGIT_BASE);
    assign w_key      = r_pool[DATA_W-1:0] - w_base_mul;
    assign w_result   = (i_mode == MODE_DECRYPT) ? (r_item.data - w_key)
                                                 : (r_item.data + w_key);

    assign w_slot_free = !r_out_valid || i_m_tready;
    assign o_pop       = (r_state == ST_IDLE) && i_q.valid;

    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = r_out_item.data;
    assign o_m_tlast   = r_out_item.last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_residue   <= SCALE_POWER;
            r_pool      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_q.valid) begin
                        r_item  <= i_q.item;
                        r_state <= ST_CHECK;
                    end
                end
                ST_CHECK: begin
                    if (r_pool <= POOL_W'(DIGIT_BASE)) begin
                        r_state <= ST_MUL;
                    end else begin
                        r_state <= ST_DIV;
                    end
                end
                ST_MUL: begin
                    r_quot  <= w_mix_prod[MUL_W-1:PRIME_SHIFT];
                    r_prod  <= w_scaled;
                    r_state <= ST_REM;
                end
                ST_REM: begin
                    r_rem   <= r_prod - w_quot_mul;
                    r_state <= ST_FIX;
                end
                ST_FIX: begin
                    if (w_over) begin
                        r_residue <= w_fix;
                        r_pool    <= r_quot + 1'b1;
                    end else begin
                        r_residue <= r_rem[RES_W-1:0];
                        r_pool    <= r_quot;
                    end
                    r_state <= ST_CHECK;
                end
                ST_DIV: begin
                    r_quot  <= POOL_W'(w_pool_mul[MUL_W-1:BASE_SHIFT]);
                    r_state <= ST_KEY;
                end
                ST_KEY: begin
                    r_pool      <= r_quot;
                    r_item.data <= w_result;
                    r_state     <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (w_slot_free) begin
                        r_out_valid <= 1'b1;
                        r_out_item  <= r_item;
                        if (r_item.last) begin
                            r_residue <= SCALE_POWER;
                            r_pool    <= '0;
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/akc_checker.sv
// ----------------------------------------------------------------------------
// akc_checker
// Port-level checks for the additive keystream byte cipher.
// ----------------------------------------------------------------------------
`default_nettype none

module akc_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_m_tvalid,
    input wire logic        i_m_tready,
    input wire logic [7:0]  o_m_tdata,
    input wire logic        o_m_tlast,
    input wire logic        psel,
    input wire logic        penable,
    input wire logic        pwrite,
    input wire logic [2:0]  paddr,
    input wire logic [31:0] pwdata,
    input wire logic [31:0] prdata,
    input wire logic        pready
);

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

    a_mode_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (psel && penable && pwrite && pready && (paddr[2] == 1'b0))
        ##1 (paddr[2] == 1'b0) |-> (prdata[0] == $past(pwdata[0])))
        else $error("mode register readback mismatch");

    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("output valid dropped while stalled");

    a_data_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> $stable(o_m_tdata) && $stable(o_m_tlast))
        else $error("output payload changed while stalled");

endmodule

bind additive_keystream_byte_cipher akc_checker u_akc_checker (.*);

`default_nettype wire
